### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMHL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SMHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/smhl_pkg.sv
// ---------------------------------------------------------------------------
// smhl_pkg
// Shared constants, codes and control structures of the sector map lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smhl_pkg;

    localparam int unsigned BUCKETS_DEF = 997;
    localparam int unsigned ENTRIES_DEF = 4096;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        RES_OK,
        RES_INSERTED,
        RES_FOUND,
        RES_MISS,
        RES_FULL
    } res_t;

    typedef struct packed {
        logic load_in;
        logic mod_start;
        logic sweep_step;
        logic count_clear;
        logic head_rd;
        logic ent_rd_head;
        logic ent_rd_link;
        logic insert_wr;
        logic res_load;
        res_t res_sel;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic full;
        logic mod_done;
        logic sweep_last;
        logic head_end;
        logic key_match;
        logic link_end;
    } stat_t;

endpackage

`default_nettype wire

### sv/sector_map_hash_lookup_core.sv
// ---------------------------------------------------------------------------
// sector_map_hash_lookup_core
// Chained hash table from 32-bit sector numbers to image positions.
// ---------------------------------------------------------------------------
// One operation is processed at a time. After reset the block sweeps every
// bucket head to empty with s_tready low. The bucket of a key comes from a
// remainder unit that folds the key bits above the low ten onto them (by
// default 1024 is 27 modulo 997) and finishes with compare and subtract
// steps, as many as the key needs. A lookup then reads one chain entry after
// another from the entry memory until the key matches or the chain ends. A
// clear sweeps the head memory again; the unused op code and a refused insert
// go straight to the result. The next input transfer is accepted while a
// result still waits on the output; the block then holds its own result back
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sector_map_hash_lookup_core #(
    parameter int unsigned BUCKETS = smhl_pkg::BUCKETS_DEF,
    parameter int unsigned ENTRIES = smhl_pkg::ENTRIES_DEF,
    localparam int unsigned CW    = $clog2(ENTRIES + 1),
    localparam int unsigned IN_W  = ((smhl_pkg::OP_W + smhl_pkg::KEY_W + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((smhl_pkg::STATUS_W + 2 * CW + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // s_tdata fields, lowest first: op, sector
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // m_tdata fields, lowest first: status, position, entry_count
    output logic [OUT_W-1:0]      m_tdata
);

    smhl_pkg::cmd_t  cmd;
    smhl_pkg::stat_t stat;

    logic [smhl_pkg::STATUS_W-1:0] out_status;
    logic [CW-1:0]                 out_pos;
    logic [CW-1:0]                 out_cnt;
    logic                          out_failed;

    smhl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smhl_datapath #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

    assign out_status = m_tdata[smhl_pkg::STATUS_W-1:0];
    assign out_pos    = m_tdata[smhl_pkg::STATUS_W +: CW];
    assign out_cnt    = m_tdata[smhl_pkg::STATUS_W + CW +: CW];
    assign out_failed = (out_status != smhl_pkg::ST_OK);

    `SMHL_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SMHL_ASSERT_SAME(a_pos_in_table, aclk, aresetn, m_tvalid, out_pos <= out_cnt)
    `SMHL_ASSERT_SAME(a_fail_no_pos, aclk, aresetn, m_tvalid && out_failed, out_pos == '0)
    `SMHL_ASSERT_SAME(a_count_bound, aclk, aresetn, m_tvalid, out_cnt <= CW'(ENTRIES))

endmodule

`default_nettype wire

### sv/smhl_mod_unit.sv
// ---------------------------------------------------------------------------
// smhl_mod_unit
// Key modulo bucket count by repeated folding and final compare and subtract steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smhl_mod_unit #(
    parameter int unsigned BUCKETS = smhl_pkg::BUCKETS_DEF,
    localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [smhl_pkg::KEY_W-1:0] key,
    output logic                            done,
    output logic [BKT_W-1:0]                rem
);

    localparam int unsigned KW   = smhl_pkg::KEY_W;
    localparam int unsigned HI_W = KW - BKT_W;

    // Weight of the bits above the low BKT_W bits, reduced modulo the bucket count.
    localparam logic [BKT_W-1:0] FOLD_K   = BKT_W'((64'd1 << BKT_W) % BUCKETS);
    localparam logic [KW-1:0]    FOLD_LIM = KW'(64'd1 << (BKT_W + 1));
    localparam logic [KW-1:0]    BKT_K    = KW'(BUCKETS);

    logic [KW-1:0] x_reg, x_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW-1:0] fold_sum;

    // hi * 2^BKT_W + lo is congruent to hi * FOLD_K + lo, which is strictly smaller.
    assign fold_sum = {{BKT_W{1'b0}}, x_reg[KW-1:BKT_W]} * {{HI_W{1'b0}}, FOLD_K}
                    + {{HI_W{1'b0}}, x_reg[BKT_W-1:0]};

    always_comb begin
        x_next    = x_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            x_next    = key;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // Below FOLD_LIM at most three subtractions remain.
            if (x_reg >= FOLD_LIM) begin
                x_next = fold_sum;
            end else if (x_reg >= BKT_K) begin
                x_next = x_reg - BKT_K;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
    end

    assign done = done_reg;
    assign rem  = x_reg[BKT_W-1:0];

endmodule

`default_nettype wire

### sv/smhl_datapath.sv
// ---------------------------------------------------------------------------
// smhl_datapath
// Bucket head memory, entry memories, key count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smhl_datapath #(
    parameter int unsigned BUCKETS = smhl_pkg::BUCKETS_DEF,
    parameter int unsigned ENTRIES = smhl_pkg::ENTRIES_DEF,
    localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int unsigned CW    = $clog2(ENTRIES + 1),
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int unsigned IN_W  = ((smhl_pkg::OP_W + smhl_pkg::KEY_W + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((smhl_pkg::STATUS_W + 2 * CW + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire smhl_pkg::cmd_t   cmd,
    output smhl_pkg::stat_t       stat,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam logic [CW-1:0] END_MARK = CW'(ENTRIES);

    logic [smhl_pkg::KEY_W-1:0] head_unused_key;
    logic [smhl_pkg::KEY_W-1:0] in_key;
    logic                       mod_done;
    logic [BKT_W-1:0]           bkt;

    logic [smhl_pkg::KEY_W-1:0] key_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [BKT_W-1:0]           sweep_idx_reg, sweep_idx_next;
    logic [CW-1:0]              j_reg;
    logic [CW-1:0]              head_q_reg;
    logic [smhl_pkg::KEY_W-1:0] ent_key_q_reg;
    logic [CW-1:0]              ent_link_q_reg;
    logic [smhl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CW-1:0]              res_pos_reg, res_pos_next;
    logic [CW-1:0]              res_count_reg, res_count_next;
    logic [CW-1:0]              ent_addr;
    logic                       sweep_last;

    logic [CW-1:0]              head_mem [0:BUCKETS-1];
    logic [smhl_pkg::KEY_W-1:0] key_mem  [0:ENTRIES-1];
    logic [CW-1:0]              link_mem [0:ENTRIES-1];

    assign in_key          = s_tdata[smhl_pkg::OP_W +: smhl_pkg::KEY_W];
    assign head_unused_key = in_key;

    smhl_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .key     (head_unused_key),
        .done    (mod_done),
        .rem     (bkt)
    );

    assign sweep_last = (sweep_idx_reg == BKT_W'(BUCKETS - 1));
    assign ent_addr   = cmd.ent_rd_head ? head_q_reg : ent_link_q_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.count_clear) begin
            count_next = '0;
        end else if (cmd.insert_wr) begin
            count_next = count_reg + 1'b1;
        end

        sweep_idx_next = sweep_idx_reg;
        if (cmd.sweep_step) begin
            sweep_idx_next = sweep_last ? '0 : sweep_idx_reg + 1'b1;
        end

        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_count_next  = res_count_reg;
        if (cmd.res_load) begin
            res_count_next = count_reg;
            case (cmd.res_sel)
                smhl_pkg::RES_INSERTED: begin
                    res_status_next = smhl_pkg::ST_OK;
                    res_pos_next    = count_reg;
                end
                smhl_pkg::RES_FOUND: begin
                    res_status_next = smhl_pkg::ST_OK;
                    res_pos_next    = j_reg + 1'b1;
                end
                smhl_pkg::RES_MISS: begin
                    res_status_next = smhl_pkg::ST_MISS;
                    res_pos_next    = '0;
                end
                smhl_pkg::RES_FULL: begin
                    res_status_next = smhl_pkg::ST_FULL;
                    res_pos_next    = '0;
                end
                default: begin
                    res_status_next = smhl_pkg::ST_OK;
                    res_pos_next    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sweep_idx_reg <= '0;
        end else begin
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_count_reg  <= res_count_next;
        if (cmd.load_in) begin
            key_reg <= in_key;
        end
    end

    // Bucket heads: the sweep writes the end marker, an insert the new index.
    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            head_mem[sweep_idx_reg] <= END_MARK;
        end else if (cmd.insert_wr) begin
            head_mem[bkt] <= count_reg;
        end
        if (cmd.head_rd) begin
            head_q_reg <= head_mem[bkt];
        end
    end

    // Entries: the new key is linked in front of the old bucket head.
    always_ff @(posedge aclk) begin
        if (cmd.insert_wr) begin
            key_mem[count_reg[IDX_W-1:0]]  <= key_reg;
            link_mem[count_reg[IDX_W-1:0]] <= head_q_reg;
        end
        if (cmd.ent_rd_head || cmd.ent_rd_link) begin
            ent_key_q_reg  <= key_mem[ent_addr[IDX_W-1:0]];
            ent_link_q_reg <= link_mem[ent_addr[IDX_W-1:0]];
            j_reg          <= ent_addr;
        end
    end

    always_comb begin
        stat.in_op      = smhl_pkg::op_t'(s_tdata[smhl_pkg::OP_W-1:0]);
        stat.full       = (count_reg == END_MARK);
        stat.mod_done   = mod_done;
        stat.sweep_last = sweep_last;
        stat.head_end   = (head_q_reg == END_MARK);
        stat.key_match  = (ent_key_q_reg == key_reg);
        stat.link_end   = (ent_link_q_reg == END_MARK);
    end

    assign m_tdata = OUT_W'({res_count_reg, res_pos_reg, res_status_reg});

endmodule

`default_nettype wire

### sv/smhl_ctrl.sv
// ---------------------------------------------------------------------------
// smhl_ctrl
// Operation sequencer: sweep, remainder, head read, chain walk and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smhl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire smhl_pkg::stat_t stat,
    output smhl_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CLEAR = 7'b0000100,
        S_MOD   = 7'b0001000,
        S_HCHK  = 7'b0010000,
        S_ECHK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    smhl_pkg::res_t    res_reg, res_next;
    smhl_pkg::op_t     op_reg, op_next;
    logic              out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        res_next       = res_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    op_next     = stat.in_op;
                    case (stat.in_op)
                        smhl_pkg::OP_CLEAR: begin
                            cmd.count_clear = 1'b1;
                            res_next        = smhl_pkg::RES_OK;
                            state_next      = S_CLEAR;
                        end
                        smhl_pkg::OP_INSERT: begin
                            if (stat.full) begin
                                res_next   = smhl_pkg::RES_FULL;
                                state_next = S_DONE;
                            end else begin
                                cmd.mod_start = 1'b1;
                                state_next    = S_MOD;
                            end
                        end
                        smhl_pkg::OP_LOOKUP: begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                        default: begin
                            res_next   = smhl_pkg::RES_OK;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_HCHK;
                end
            end
            S_HCHK: begin
                if (op_reg == smhl_pkg::OP_INSERT) begin
                    cmd.insert_wr = 1'b1;
                    res_next      = smhl_pkg::RES_INSERTED;
                    state_next    = S_DONE;
                end else if (stat.head_end) begin
                    res_next   = smhl_pkg::RES_MISS;
                    state_next = S_DONE;
                end else begin
                    cmd.ent_rd_head = 1'b1;
                    state_next      = S_ECHK;
                end
            end
            S_ECHK: begin
                // Each mismatch issues the read of the next link straight away.
                if (stat.key_match) begin
                    res_next   = smhl_pkg::RES_FOUND;
                    state_next = S_DONE;
                end else if (stat.link_end) begin
                    res_next   = smhl_pkg::RES_MISS;
                    state_next = S_DONE;
                end else begin
                    cmd.ent_rd_link = 1'b1;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        cmd.res_sel = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            res_reg       <= smhl_pkg::RES_OK;
            op_reg        <= smhl_pkg::OP_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### test/tb_sector_map_hash_lookup_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sector_map_hash_lookup_core
// Self-checking bench for the chained hash lookup of sector numbers.
// ---------------------------------------------------------------------------
// A queue of operations is filled at time zero: a short directed sequence and
// random mixes of insert, lookup, clear and the unused code, with keys that
// often land in one crowded bucket so that chains grow long. The driver
// presents the queue on the input stream with random idle bursts; each
// accepted transfer is run through a local copy of the table to get the
// expected result, which the monitor compares with the output stream while
// it stalls at random.
// ---------------------------------------------------------------------------

module tb_sector_map_hash_lookup_core;

    localparam int unsigned BUCKETS    = smhl_pkg::BUCKETS_DEF;
    localparam int unsigned ENTRIES    = smhl_pkg::ENTRIES_DEF;
    localparam int unsigned CW         = $clog2(ENTRIES + 1);
    localparam int unsigned IN_W       = ((smhl_pkg::OP_W + smhl_pkg::KEY_W + 7) / 8) * 8;
    localparam int unsigned OUT_W      = ((smhl_pkg::STATUS_W + 2 * CW + 7) / 8) * 8;
    localparam int unsigned QUIET_TAIL = 200;
    localparam int unsigned DRAIN_WAIT = 64;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct {
        smhl_pkg::op_t op;
        logic [31:0]   sector;
        bit            hold;     // sender waits here until every result is in
    } sector_op_t;

    typedef struct packed {
        logic [smhl_pkg::STATUS_W-1:0] status;
        logic [CW-1:0]                 position;
        logic [CW-1:0]                 entry_count;
    } map_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // s_tdata fields, lowest first: op, sector
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // m_tdata fields, lowest first: status, position, entry_count
    logic [OUT_W-1:0] m_tdata;

    sector_op_t   pending_ops[$];
    map_result_t  expected_results[$];
    logic [31:0]  live_keys[$];

    // Local copy of the table.
    logic [CW-1:0] chain_head[BUCKETS];
    logic [CW-1:0] next_link[ENTRIES];
    logic [31:0]   stored_sector[ENTRIES];
    logic [CW-1:0] held_count;

    smhl_pkg::op_t sent_op;
    logic [31:0]   sent_sector;
    int unsigned   send_gap;
    int unsigned   stall_left;
    int unsigned   error_count;
    int unsigned   cycle_count;
    int unsigned   hot_bucket;

    sector_map_hash_lookup_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic map_result_t apply_operation(smhl_pkg::op_t op, logic [31:0] sector);
        map_result_t   r;
        int unsigned   b;
        logic [CW-1:0] j;
        int unsigned   steps;
        bit            found;
        r.status   = smhl_pkg::ST_OK;
        r.position = '0;
        b          = sector % BUCKETS;
        case (op)
            smhl_pkg::OP_CLEAR: begin
                foreach (chain_head[i]) chain_head[i] = CW'(ENTRIES);
                held_count = '0;
            end
            smhl_pkg::OP_INSERT: begin
                if (held_count >= ENTRIES) begin
                    r.status = smhl_pkg::ST_FULL;
                end else begin
                    stored_sector[held_count] = sector;
                    next_link[held_count]     = chain_head[b];
                    chain_head[b]             = held_count;
                    held_count                = held_count + 1'b1;
                    r.position                = held_count;
                end
            end
            smhl_pkg::OP_LOOKUP: begin
                // The newest copy of a key sits nearest the head of its chain.
                j     = chain_head[b];
                steps = 0;
                found = 1'b0;
                while (!found && j < ENTRIES && steps < held_count) begin
                    if (stored_sector[j] == sector) begin
                        found      = 1'b1;
                        r.position = j + 1'b1;
                    end else begin
                        j     = next_link[j];
                        steps = steps + 1;
                    end
                end
                r.status = found ? smhl_pkg::ST_OK : smhl_pkg::ST_MISS;
            end
            default: ;
        endcase
        r.entry_count = held_count;
        return r;
    endfunction

    task automatic queue_op(input smhl_pkg::op_t op, input logic [31:0] sector);
        pending_ops.push_back('{op: op, sector: sector, hold: 1'b0});
    endtask

    task automatic queue_hold();
        pending_ops.push_back('{op: smhl_pkg::OP_NONE, sector: '0, hold: 1'b1});
    endtask

    // A key that lands in the crowded bucket, so that its chain grows long.
    function automatic logic [31:0] crowded_key();
        return hot_bucket + BUCKETS * $urandom_range(0, 4307000);
    endfunction

    task automatic queue_random_ops(input int unsigned count);
        int unsigned   sel;
        smhl_pkg::op_t op;
        logic [31:0]   key;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 999);
            if (sel < 15)       op = smhl_pkg::OP_CLEAR;
            else if (sel < 45)  op = smhl_pkg::OP_NONE;
            else if (sel < 460) op = smhl_pkg::OP_INSERT;
            else                op = smhl_pkg::OP_LOOKUP;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                key = $urandom;
            end else if (sel < 75) begin
                key = crowded_key();
            end else if (sel < 90 && live_keys.size() > 0) begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else begin
                case ($urandom_range(0, 4))
                    0:       key = 32'h0000_0000;
                    1:       key = 32'hFFFF_FFFF;
                    2:       key = 32'hFFFF_FFFE;
                    3:       key = 32'h8000_0000;
                    default: key = BUCKETS;
                endcase
            end
            // Most lookups ask for a key that is held, so that hits are common.
            if (op == smhl_pkg::OP_LOOKUP && live_keys.size() > 0 &&
                $urandom_range(0, 1) == 0)
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            if (op == smhl_pkg::OP_INSERT) live_keys.push_back(key);
            if (op == smhl_pkg::OP_CLEAR)  live_keys.delete();
            queue_op(op, key);
        end
    endtask

    // Driver: presents queued operations and predicts each accepted transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_operation(sent_op, sent_sector));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0 && pending_ops[0].hold) begin
                    s_tvalid <= 1'b0;
                    if (expected_results.size() == 0) void'(pending_ops.pop_front());
                end else if (pending_ops.size() >= QUIET_TAIL &&
                             $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    sent_op     = pending_ops[0].op;
                    sent_sector = pending_ops[0].sector;
                    void'(pending_ops.pop_front());
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_W'({sent_sector, sent_op});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer against the oldest expectation.
    always @(posedge aclk) begin
        map_result_t want;
        map_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[smhl_pkg::STATUS_W-1:0];
                got.position    = m_tdata[smhl_pkg::STATUS_W +: CW];
                got.entry_count = m_tdata[smhl_pkg::STATUS_W + CW +: CW];
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d position %0d entry_count %0d",
                           got.status, got.position, got.entry_count);
                    error_count = error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        error_count = error_count + 1;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        error_count = error_count + 1;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, got.entry_count);
                        error_count = error_count + 1;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else if (pending_ops.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        hot_bucket  = $urandom_range(0, BUCKETS - 1);
        foreach (chain_head[i]) chain_head[i] = CW'(ENTRIES);
        held_count = '0;

        // Directed: empty table, chain order in bucket zero, duplicates, clear.
        queue_op(smhl_pkg::OP_LOOKUP, 32'd0);
        queue_op(smhl_pkg::OP_NONE,   32'hFFFF_FFFF);
        queue_op(smhl_pkg::OP_INSERT, 32'd0);
        queue_op(smhl_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_op(smhl_pkg::OP_INSERT, BUCKETS);
        queue_op(smhl_pkg::OP_INSERT, 2 * BUCKETS);
        queue_op(smhl_pkg::OP_LOOKUP, 32'd0);
        queue_op(smhl_pkg::OP_LOOKUP, BUCKETS);
        queue_op(smhl_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        queue_op(smhl_pkg::OP_LOOKUP, 3 * BUCKETS);
        queue_op(smhl_pkg::OP_INSERT, 32'd0);
        queue_op(smhl_pkg::OP_LOOKUP, 32'd0);
        queue_op(smhl_pkg::OP_LOOKUP, 32'h5555_5555);
        queue_op(smhl_pkg::OP_INSERT, 32'hAAAA_AAAA);
        queue_op(smhl_pkg::OP_LOOKUP, 32'hAAAA_AAAA);
        queue_op(smhl_pkg::OP_NONE,   32'h0000_0000);
        queue_op(smhl_pkg::OP_CLEAR,  32'hFFFF_FFFF);
        queue_op(smhl_pkg::OP_LOOKUP, 32'd0);
        queue_op(smhl_pkg::OP_NONE,   32'h1234_5678);
        queue_op(smhl_pkg::OP_INSERT, 32'h1234_5678);
        queue_op(smhl_pkg::OP_LOOKUP, 32'h1234_5678);
        live_keys.push_back(32'h1234_5678);
        queue_hold();

        queue_random_ops(800);

        // Start the second mix from an empty table once everything has drained.
        queue_hold();
        queue_op(smhl_pkg::OP_CLEAR, 32'd0);
        live_keys.delete();

        queue_random_ops(830);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
